[design/keypad_four_function_calculator_core_assert.svh]
// Assertion macros for the keypad calculator core.
// KFC_ASSERT_SAME checks a consequent in the same cycle, KFC_ASSERT_NEXT in the cycle after.
`ifndef KEYPAD_FOUR_FUNCTION_CALCULATOR_CORE_ASSERT_SVH
`define KEYPAD_FOUR_FUNCTION_CALCULATOR_CORE_ASSERT_SVH

`ifndef SYNTH

`define KFC_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("keypad calculator core: check failed");

`define KFC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("keypad calculator core: check failed");

`else

`define KFC_ASSERT_SAME(name, clk, rst_n, ante, cons)

`define KFC_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

[design/kfc_pkg.sv]
package kfc_pkg;

    // Number format: signed fixed point, FRAC_BITS of VALUE_WIDTH bits are fraction
    localparam int VALUE_WIDTH = 64;
    localparam int FRAC_BITS   = 16;

    // Digit entry and add/sub run in a few guard bits above the value width
    localparam int SUM_W   = VALUE_WIDTH + 5;
    // Dividend (magnitude shifted up by the fraction) and quotient width
    localparam int QUO_W   = VALUE_WIDTH + FRAC_BITS;
    localparam int CNT_W   = $clog2(QUO_W);
    localparam int DIV_LAST = QUO_W - 1;

    // Multiplier: magnitudes padded to two 32 bit chunks, four partial products
    localparam int CHUNK_W  = 32;
    localparam int MAG_W    = 2 * CHUNK_W;
    localparam int PROD_W   = 2 * MAG_W;
    localparam int MUL_LAST = 3;

    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [VALUE_WIDTH-1:0]        VAL_HALF = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // Key codes
    localparam logic [7:0] KEY_0      = 8'h30;
    localparam logic [7:0] KEY_9      = 8'h39;
    localparam logic [7:0] KEY_PLUS   = 8'h2B;
    localparam logic [7:0] KEY_MINUS  = 8'h2D;
    localparam logic [7:0] KEY_STAR   = 8'h2A;
    localparam logic [7:0] KEY_SLASH  = 8'h2F;
    localparam logic [7:0] KEY_EQUALS = 8'h3D;
    localparam logic [7:0] KEY_HASH   = 8'h23;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } t_oper;

    typedef enum logic [1:0] {
        KIND_DIGIT  = 2'd0,
        KIND_OPER   = 2'd1,
        KIND_EQUALS = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    // Datapath operation of one microcode step
    typedef enum logic [4:0] {
        UOP_IDLE,
        UOP_DIG_MUL,
        UOP_DIG_ADD,
        UOP_SUM_SAT,
        UOP_DIG_WB,
        UOP_OPER,
        UOP_CLEAR,
        UOP_EQ_SEL,
        UOP_ADD,
        UOP_MUL_INIT,
        UOP_MUL_PP,
        UOP_MUL_ACC,
        UOP_MUL_SAT,
        UOP_FINISH,
        UOP_DIV_INIT,
        UOP_DIV_STEP,
        UOP_DIV_SAT
    } t_uop;

    // Sequencing of one microcode step
    typedef enum logic [2:0] {
        COND_NEXT,     // fall through
        COND_GOTO,     // jump to target
        COND_KEY,      // dispatch on the accepted key, hold while no request
        COND_PENDING,  // dispatch on the pending operator
        COND_LOOP,     // jump to target until the step counter hits its limit
        COND_DBZ,      // jump to target when the divisor is zero
        COND_EMIT      // jump to target once the output register is free, else hold
    } t_cond;

    localparam int PC_W = 5;

    typedef struct packed {
        t_uop            uop;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ctrl;

    // Microcode addresses
    localparam logic [PC_W-1:0] PC_IDLE     = PC_W'(0);
    localparam logic [PC_W-1:0] PC_DIG_MUL  = PC_W'(1);
    localparam logic [PC_W-1:0] PC_DIG_ADD  = PC_W'(2);
    localparam logic [PC_W-1:0] PC_DIG_SAT  = PC_W'(3);
    localparam logic [PC_W-1:0] PC_DIG_WB   = PC_W'(4);
    localparam logic [PC_W-1:0] PC_OPER     = PC_W'(5);
    localparam logic [PC_W-1:0] PC_CLEAR    = PC_W'(6);
    localparam logic [PC_W-1:0] PC_EQ_SEL   = PC_W'(7);
    localparam logic [PC_W-1:0] PC_ADD      = PC_W'(8);
    localparam logic [PC_W-1:0] PC_ADD_SAT  = PC_W'(9);
    localparam logic [PC_W-1:0] PC_MUL_INIT = PC_W'(10);
    localparam logic [PC_W-1:0] PC_MUL_PP   = PC_W'(11);
    localparam logic [PC_W-1:0] PC_MUL_ACC  = PC_W'(12);
    localparam logic [PC_W-1:0] PC_MUL_SAT  = PC_W'(13);
    localparam logic [PC_W-1:0] PC_FINISH   = PC_W'(14);
    localparam logic [PC_W-1:0] PC_DIV_INIT = PC_W'(15);
    localparam logic [PC_W-1:0] PC_DIV_STEP = PC_W'(16);
    localparam logic [PC_W-1:0] PC_DIV_SAT  = PC_W'(17);
    localparam logic [PC_W-1:0] PC_LAST     = PC_DIV_SAT;

    // Control store
    function automatic t_ctrl ctrl_rom(input logic [PC_W-1:0] addr);
        t_ctrl cw;
        unique case (addr)
            PC_IDLE:     cw = '{UOP_IDLE,     COND_KEY,     PC_IDLE};
            PC_DIG_MUL:  cw = '{UOP_DIG_MUL,  COND_NEXT,    PC_IDLE};
            PC_DIG_ADD:  cw = '{UOP_DIG_ADD,  COND_NEXT,    PC_IDLE};
            PC_DIG_SAT:  cw = '{UOP_SUM_SAT,  COND_NEXT,    PC_IDLE};
            PC_DIG_WB:   cw = '{UOP_DIG_WB,   COND_EMIT,    PC_IDLE};
            PC_OPER:     cw = '{UOP_OPER,     COND_EMIT,    PC_IDLE};
            PC_CLEAR:    cw = '{UOP_CLEAR,    COND_EMIT,    PC_IDLE};
            PC_EQ_SEL:   cw = '{UOP_EQ_SEL,   COND_PENDING, PC_IDLE};
            PC_ADD:      cw = '{UOP_ADD,      COND_NEXT,    PC_IDLE};
            PC_ADD_SAT:  cw = '{UOP_SUM_SAT,  COND_GOTO,    PC_FINISH};
            PC_MUL_INIT: cw = '{UOP_MUL_INIT, COND_NEXT,    PC_IDLE};
            PC_MUL_PP:   cw = '{UOP_MUL_PP,   COND_NEXT,    PC_IDLE};
            PC_MUL_ACC:  cw = '{UOP_MUL_ACC,  COND_LOOP,    PC_MUL_PP};
            PC_MUL_SAT:  cw = '{UOP_MUL_SAT,  COND_GOTO,    PC_FINISH};
            PC_FINISH:   cw = '{UOP_FINISH,   COND_EMIT,    PC_IDLE};
            PC_DIV_INIT: cw = '{UOP_DIV_INIT, COND_DBZ,     PC_FINISH};
            PC_DIV_STEP: cw = '{UOP_DIV_STEP, COND_LOOP,    PC_DIV_STEP};
            PC_DIV_SAT:  cw = '{UOP_DIV_SAT,  COND_GOTO,    PC_FINISH};
            default:     cw = '{UOP_IDLE,     COND_GOTO,    PC_IDLE};
        endcase
        return cw;
    endfunction

    function automatic t_oper oper_of_key(input logic [7:0] key);
        t_oper op;
        unique case (key)
            KEY_PLUS:  op = OP_ADD;
            KEY_MINUS: op = OP_SUB;
            KEY_STAR:  op = OP_MUL;
            default:   op = OP_DIV;
        endcase
        return op;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] abs_mag(input logic signed [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH-1:0] u;
        u = unsigned'(v);
        return v[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - u) : u;
    endfunction

    // Clamp a signed wide sum to the value range
    function automatic logic signed [VALUE_WIDTH-1:0] sat_sum(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] mx;
        logic signed [SUM_W-1:0] mn;
        mx = SUM_W'(VAL_MAX);
        mn = SUM_W'(VAL_MIN);
        if (s > mx) begin
            return VAL_MAX;
        end else if (s < mn) begin
            return VAL_MIN;
        end
        return s[VALUE_WIDTH-1:0];
    endfunction

    // Clamp a sign and magnitude to the value range
    function automatic logic signed [VALUE_WIDTH-1:0] sat_mag(input logic neg,
                                                              input logic [PROD_W-1:0] mag);
        logic [PROD_W-1:0]      lim;
        logic [PROD_W-1:0]      m;
        logic [VALUE_WIDTH-1:0] mv;
        lim = PROD_W'(VAL_HALF);
        if (!neg) begin
            lim = lim - PROD_W'(1);
        end
        m  = (mag > lim) ? lim : mag;
        mv = m[VALUE_WIDTH-1:0];
        return neg ? (VALUE_WIDTH'(0) - mv) : mv;
    endfunction

    // Integer part, truncated toward zero, clamped to 32 bits
    function automatic logic signed [31:0] shown_int(input logic signed [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH-1:0] mag;
        logic [64:0]            m;
        mag = abs_mag(v);
        m   = 65'(mag >> FRAC_BITS);
        if (v[VALUE_WIDTH-1]) begin
            if (m > 65'h0_8000_0000) begin
                m = 65'h0_8000_0000;
            end
            return 32'(65'd0 - m);
        end
        if (m > 65'h0_7FFF_FFFF) begin
            m = 65'h0_7FFF_FFFF;
        end
        return 32'(m);
    endfunction

endpackage

[design/keypad_four_function_calculator_core.sv]
// Keypad calculator core: one ASCII key per request, at most one result per key. Values are
// signed fixed point (kfc_pkg::VALUE_WIDTH bits, kfc_pkg::FRAC_BITS fraction bits), every
// operation saturates. A small microcode program steps a shared datapath; the input side
// stalls until the program is back at its idle step. A multiply forms four 32x32 partial
// products, each a multiply step and an accumulate step; a divide runs a restoring divider,
// one quotient bit per cycle, which a division by zero skips. Results go to an output
// register, so the next key is taken while a result waits; a program that reaches its
// output step while that register is still held waits there. Keys outside digits,
// + - * /, = and # are taken and dropped.
module keypad_four_function_calculator_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_key_code,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_event_kind,
    output logic [7:0]         o_echo_char,
    output logic signed [31:0] o_shown_value,
    output logic               o_divide_by_zero
);

`include "keypad_four_function_calculator_core_assert.svh"

    localparam int VW = kfc_pkg::VALUE_WIDTH;

    // Sequencer
    logic [kfc_pkg::PC_W-1:0] r_pc, n_pc;
    kfc_pkg::t_ctrl           ctrl;
    logic [kfc_pkg::PC_W-1:0] key_entry;
    logic                     in_accept;
    logic                     in_stall;
    logic                     out_free;
    logic                     emit_go;
    logic                     finish_go;
    logic                     div_step;
    logic                     loop_done;

    // Architectural state
    logic signed [VW-1:0] r_first, n_first;
    logic signed [VW-1:0] r_second, n_second;
    logic signed [VW-1:0] r_last, n_last;
    kfc_pkg::t_oper       r_pending, n_pending;
    logic                 r_entering, n_entering;

    // Work registers
    logic [7:0]                       r_key, n_key;
    logic signed [kfc_pkg::SUM_W-1:0] r_sum, n_sum;
    logic signed [VW-1:0]             r_res, n_res;
    logic                             r_dbz, n_dbz;
    logic                             r_neg, n_neg;
    logic [kfc_pkg::MAG_W-1:0]        r_ma, n_ma;
    logic [kfc_pkg::MAG_W-1:0]        r_mb, n_mb;
    logic [kfc_pkg::MAG_W-1:0]        r_prod, n_prod;
    logic [1:0]                       r_pshift, n_pshift;
    logic [kfc_pkg::PROD_W-1:0]       r_acc, n_acc;
    logic [kfc_pkg::QUO_W-1:0]        r_num, n_num;
    logic [VW-1:0]                    r_rem, n_rem;
    logic [VW-1:0]                    r_den, n_den;
    logic [kfc_pkg::CNT_W-1:0]        r_cnt, n_cnt;

    // Output register
    logic               r_out_valid, n_out_valid;
    kfc_pkg::t_kind     r_out_kind, n_out_kind;
    logic [7:0]         r_out_char, n_out_char;
    logic signed [31:0] r_out_value, n_out_value;
    logic               r_out_dbz, n_out_dbz;

    // Datapath temporaries
    logic signed [VW-1:0]             sel_op;
    logic signed [kfc_pkg::SUM_W-1:0] op_ext;
    logic signed [kfc_pkg::SUM_W-1:0] a_ext;
    logic signed [kfc_pkg::SUM_W-1:0] b_ext;
    logic [3:0]                       digit;
    logic signed [kfc_pkg::SUM_W-1:0] dig_ext;
    logic [VW-1:0]                    mag_a;
    logic [VW-1:0]                    mag_b;
    logic [kfc_pkg::CHUNK_W-1:0]      a_chunk;
    logic [kfc_pkg::CHUNK_W-1:0]      b_chunk;
    logic [kfc_pkg::PROD_W-1:0]       addend;
    logic [VW:0]                      trial;
    logic [VW:0]                      diff;

    assign ctrl      = kfc_pkg::ctrl_rom(r_pc);
    assign in_stall  = (r_pc != kfc_pkg::PC_IDLE);
    assign in_accept = i_in_valid && !in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit_go   = (ctrl.cond == kfc_pkg::COND_EMIT) && out_free;
    assign finish_go = emit_go && (ctrl.uop == kfc_pkg::UOP_FINISH);
    assign div_step  = (ctrl.uop == kfc_pkg::UOP_DIV_STEP);
    assign loop_done = div_step
                     ? (r_cnt == kfc_pkg::CNT_W'(kfc_pkg::DIV_LAST))
                     : (r_cnt == kfc_pkg::CNT_W'(kfc_pkg::MUL_LAST));

    // Key dispatch
    always_comb begin
        case (i_key_code) inside
            [kfc_pkg::KEY_0:kfc_pkg::KEY_9]:   key_entry = kfc_pkg::PC_DIG_MUL;
            kfc_pkg::KEY_PLUS, kfc_pkg::KEY_MINUS,
            kfc_pkg::KEY_STAR, kfc_pkg::KEY_SLASH: key_entry = kfc_pkg::PC_OPER;
            kfc_pkg::KEY_EQUALS:               key_entry = kfc_pkg::PC_EQ_SEL;
            kfc_pkg::KEY_HASH:                 key_entry = kfc_pkg::PC_CLEAR;
            default:                           key_entry = kfc_pkg::PC_IDLE;
        endcase
    end

    // Next step address
    always_comb begin
        unique case (ctrl.cond)
            kfc_pkg::COND_NEXT: n_pc = r_pc + kfc_pkg::PC_W'(1);
            kfc_pkg::COND_GOTO: n_pc = ctrl.target;
            kfc_pkg::COND_KEY:  n_pc = in_accept ? key_entry : r_pc;
            kfc_pkg::COND_PENDING: begin
                case (r_pending)
                    kfc_pkg::OP_ADD, kfc_pkg::OP_SUB: n_pc = kfc_pkg::PC_ADD;
                    kfc_pkg::OP_MUL:                  n_pc = kfc_pkg::PC_MUL_INIT;
                    kfc_pkg::OP_DIV:                  n_pc = kfc_pkg::PC_DIV_INIT;
                    default:                          n_pc = kfc_pkg::PC_FINISH;
                endcase
            end
            kfc_pkg::COND_LOOP:
                n_pc = loop_done ? (r_pc + kfc_pkg::PC_W'(1)) : ctrl.target;
            kfc_pkg::COND_DBZ:
                n_pc = (r_second == '0) ? ctrl.target : (r_pc + kfc_pkg::PC_W'(1));
            kfc_pkg::COND_EMIT: n_pc = out_free ? ctrl.target : r_pc;
            default:            n_pc = kfc_pkg::PC_IDLE;
        endcase
    end

    // Operand views
    always_comb begin
        sel_op  = r_entering ? r_second : r_first;
        op_ext  = kfc_pkg::SUM_W'(sel_op);
        a_ext   = kfc_pkg::SUM_W'(r_first);
        b_ext   = kfc_pkg::SUM_W'(r_second);
        digit   = 4'(r_key - kfc_pkg::KEY_0);
        dig_ext = '0;
        dig_ext[kfc_pkg::FRAC_BITS +: 4] = digit;
        mag_a   = kfc_pkg::abs_mag(r_first);
        mag_b   = kfc_pkg::abs_mag(r_second);
        a_chunk = r_cnt[1] ? r_ma[kfc_pkg::MAG_W-1:kfc_pkg::CHUNK_W]
                           : r_ma[kfc_pkg::CHUNK_W-1:0];
        b_chunk = r_cnt[0] ? r_mb[kfc_pkg::MAG_W-1:kfc_pkg::CHUNK_W]
                           : r_mb[kfc_pkg::CHUNK_W-1:0];
        case (r_pshift)
            2'd0:    addend = kfc_pkg::PROD_W'(r_prod);
            2'd1:    addend = kfc_pkg::PROD_W'(r_prod) << kfc_pkg::CHUNK_W;
            2'd2:    addend = kfc_pkg::PROD_W'(r_prod) << (2 * kfc_pkg::CHUNK_W);
            default: addend = '0;
        endcase
        trial = {r_rem, r_num[kfc_pkg::QUO_W-1]};
        diff  = trial - {1'b0, r_den};
    end

    // Datapath step
    always_comb begin
        n_first     = r_first;
        n_second    = r_second;
        n_last      = r_last;
        n_pending   = r_pending;
        n_entering  = r_entering;
        n_key       = r_key;
        n_sum       = r_sum;
        n_res       = r_res;
        n_dbz       = r_dbz;
        n_neg       = r_neg;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_prod      = r_prod;
        n_pshift    = r_pshift;
        n_acc       = r_acc;
        n_num       = r_num;
        n_rem       = r_rem;
        n_den       = r_den;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_char  = r_out_char;
        n_out_value = r_out_value;
        n_out_dbz   = r_out_dbz;

        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (ctrl.uop)
            kfc_pkg::UOP_IDLE: begin
                if (in_accept) begin
                    n_key = i_key_code;
                end
            end
            kfc_pkg::UOP_DIG_MUL: n_sum = (op_ext <<< 3) + (op_ext <<< 1);
            kfc_pkg::UOP_DIG_ADD: n_sum = r_sum + dig_ext;
            kfc_pkg::UOP_SUM_SAT: n_res = kfc_pkg::sat_sum(r_sum);
            kfc_pkg::UOP_DIG_WB: begin
                if (emit_go) begin
                    if (r_entering) begin
                        n_second = r_res;
                    end else begin
                        n_first = r_res;
                    end
                    n_out_valid = 1'b1;
                    n_out_kind  = kfc_pkg::KIND_DIGIT;
                    n_out_char  = r_key;
                    n_out_value = 32'(digit);
                    n_out_dbz   = 1'b0;
                end
            end
            kfc_pkg::UOP_OPER: begin
                if (emit_go) begin
                    n_pending   = kfc_pkg::oper_of_key(r_key);
                    n_entering  = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_kind  = kfc_pkg::KIND_OPER;
                    n_out_char  = r_key;
                    n_out_value = '0;
                    n_out_dbz   = 1'b0;
                end
            end
            kfc_pkg::UOP_CLEAR: begin
                if (emit_go) begin
                    n_first     = '0;
                    n_second    = '0;
                    n_last      = '0;
                    n_pending   = kfc_pkg::OP_NONE;
                    n_entering  = 1'b0;
                    n_out_valid = 1'b1;
                    n_out_kind  = kfc_pkg::KIND_CLEAR;
                    n_out_char  = r_key;
                    n_out_value = '0;
                    n_out_dbz   = 1'b0;
                end
            end
            kfc_pkg::UOP_EQ_SEL: begin
                // with no operator the previous result stands
                n_res = r_last;
                n_dbz = 1'b0;
            end
            kfc_pkg::UOP_ADD: begin
                n_sum = (r_pending == kfc_pkg::OP_SUB) ? (a_ext - b_ext) : (a_ext + b_ext);
            end
            kfc_pkg::UOP_MUL_INIT: begin
                n_neg = r_first[VW-1] ^ r_second[VW-1];
                n_ma  = kfc_pkg::MAG_W'(mag_a);
                n_mb  = kfc_pkg::MAG_W'(mag_b);
                n_acc = '0;
                n_cnt = '0;
            end
            kfc_pkg::UOP_MUL_PP: begin
                n_prod   = a_chunk * b_chunk;
                n_pshift = 2'(r_cnt[1]) + 2'(r_cnt[0]);
            end
            kfc_pkg::UOP_MUL_ACC: begin
                n_acc = r_acc + addend;
                n_cnt = r_cnt + kfc_pkg::CNT_W'(1);
            end
            kfc_pkg::UOP_MUL_SAT: begin
                n_res = kfc_pkg::sat_mag(r_neg, r_acc >> kfc_pkg::FRAC_BITS);
            end
            kfc_pkg::UOP_DIV_INIT: begin
                n_neg = r_first[VW-1] ^ r_second[VW-1];
                n_num = kfc_pkg::QUO_W'(mag_a) << kfc_pkg::FRAC_BITS;
                n_den = mag_b;
                n_rem = '0;
                n_cnt = '0;
                // zero divisor: saturate toward the dividend's sign
                if (r_second == '0) begin
                    n_dbz = 1'b1;
                    if (r_first == '0) begin
                        n_res = '0;
                    end else if (r_first[VW-1]) begin
                        n_res = kfc_pkg::VAL_MIN;
                    end else begin
                        n_res = kfc_pkg::VAL_MAX;
                    end
                end
            end
            kfc_pkg::UOP_DIV_STEP: begin
                // restoring step, quotient bits shift in behind the dividend
                if (!diff[VW]) begin
                    n_rem = diff[VW-1:0];
                    n_num = {r_num[kfc_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[VW-1:0];
                    n_num = {r_num[kfc_pkg::QUO_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + kfc_pkg::CNT_W'(1);
            end
            kfc_pkg::UOP_DIV_SAT: begin
                n_res = kfc_pkg::sat_mag(r_neg, kfc_pkg::PROD_W'(r_num));
            end
            kfc_pkg::UOP_FINISH: begin
                if (finish_go) begin
                    n_last      = r_res;
                    n_first     = r_res;
                    n_second    = '0;
                    n_entering  = 1'b0;
                    n_out_valid = 1'b1;
                    n_out_kind  = kfc_pkg::KIND_EQUALS;
                    n_out_char  = r_key;
                    n_out_value = kfc_pkg::shown_int(r_res);
                    n_out_dbz   = r_dbz;
                end
            end
            default: ;
        endcase
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= kfc_pkg::PC_IDLE;
            r_out_valid <= 1'b0;
            r_first     <= '0;
            r_second    <= '0;
            r_last      <= '0;
            r_pending   <= kfc_pkg::OP_NONE;
            r_entering  <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
            r_first     <= n_first;
            r_second    <= n_second;
            r_last      <= n_last;
            r_pending   <= n_pending;
            r_entering  <= n_entering;
        end
    end

    // Work and output payload
    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_sum       <= n_sum;
        r_res       <= n_res;
        r_dbz       <= n_dbz;
        r_neg       <= n_neg;
        r_ma        <= n_ma;
        r_mb        <= n_mb;
        r_prod      <= n_prod;
        r_pshift    <= n_pshift;
        r_acc       <= n_acc;
        r_num       <= n_num;
        r_rem       <= n_rem;
        r_den       <= n_den;
        r_cnt       <= n_cnt;
        r_out_kind  <= n_out_kind;
        r_out_char  <= n_out_char;
        r_out_value <= n_out_value;
        r_out_dbz   <= n_out_dbz;
    end

    assign o_in_stall       = in_stall;
    assign o_out_valid      = r_out_valid;
    assign o_event_kind     = r_out_kind;
    assign o_echo_char      = r_out_char;
    assign o_shown_value    = r_out_value;
    assign o_divide_by_zero = r_out_dbz;

    // Checks
    `KFC_ASSERT_SAME(a_pc_in_rom, i_clk, i_rst_n, 1'b1, r_pc <= kfc_pkg::PC_LAST)
    `KFC_ASSERT_SAME(a_out_from_emit, i_clk, i_rst_n, $rose(r_out_valid), $past(emit_go))
    `KFC_ASSERT_NEXT(a_equals_clears, i_clk, i_rst_n, finish_go, !r_entering && (r_second == '0))
    `KFC_ASSERT_SAME(a_div_count, i_clk, i_rst_n, div_step, int'(r_cnt) <= kfc_pkg::DIV_LAST)

endmodule

[bench/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW   = kfc_pkg::VALUE_WIDTH;
    localparam int FB   = kfc_pkg::FRAC_BITS;
    // Wide enough for a full magnitude product plus sign
    localparam int WIDE = 2 * VW + FB + 4;
    localparam int RANDOM_KEYS = 1800;

    typedef logic signed [VW-1:0]   t_value;
    typedef logic signed [WIDE-1:0] t_wide;

    typedef struct packed {
        kfc_pkg::t_kind     kind;
        logic [7:0]         echo;
        logic signed [31:0] shown;
        logic               dbz;
    } t_display;

    // Calculator state tracking and result comparison
    class calc_scoreboard;
        t_value         first_op;
        t_value         second_op;
        t_value         last_value;
        kfc_pkg::t_oper pending_op;
        bit             on_second;
        t_display       display_q[$];
        int unsigned    keys_taken = 0;
        int unsigned    results_checked = 0;
        int unsigned    equals_seen = 0;
        int unsigned    zero_divides = 0;
        int unsigned    mismatches = 0;

        function new();
            clear_state();
        endfunction

        function void clear_state();
            first_op   = '0;
            second_op  = '0;
            last_value = '0;
            pending_op = kfc_pkg::OP_NONE;
            on_second  = 1'b0;
        endfunction

        // Clamp an exact result to the value range
        function t_value clamp_value(t_wide s);
            t_wide hi;
            t_wide lo;
            hi = (t_wide'(1) <<< (VW - 1)) - 1;
            lo = -(t_wide'(1) <<< (VW - 1));
            if (s > hi) begin
                return t_value'(hi);
            end else if (s < lo) begin
                return t_value'(lo);
            end
            return t_value'(s);
        endfunction

        function logic [VW-1:0] magnitude(t_value v);
            return (v < 0) ? -v : v;
        endfunction

        function t_value shift_digit(t_value v, int digit);
            return clamp_value(t_wide'(v) * 10 + (t_wide'(digit) <<< FB));
        endfunction

        function t_value mul_sat(t_value a, t_value b);
            logic [2*VW-1:0] prod;
            t_wide           m;
            prod = {{VW{1'b0}}, magnitude(a)} * {{VW{1'b0}}, magnitude(b)};
            prod = prod >> FB;
            m    = t_wide'(prod);
            return clamp_value(((a < 0) != (b < 0)) ? -m : m);
        endfunction

        function t_value div_sat(t_value a, t_value b, output bit by_zero);
            logic [2*VW-1:0] num;
            logic [2*VW-1:0] quo;
            t_wide           m;
            by_zero = 1'b0;
            if (b == 0) begin
                // zero divisor: pin to the end of the range the dividend points at
                by_zero = 1'b1;
                if (a > 0) begin
                    return clamp_value(t_wide'(1) <<< (2 * VW));
                end else if (a < 0) begin
                    return clamp_value(-(t_wide'(1) <<< (2 * VW)));
                end
                return '0;
            end
            num = {{VW{1'b0}}, magnitude(a)} << FB;
            quo = num / {{VW{1'b0}}, magnitude(b)};
            m   = t_wide'(quo);
            return clamp_value(((a < 0) != (b < 0)) ? -m : m);
        endfunction

        // Integer part toward zero, clamped to 32 bits
        function logic signed [31:0] integer_part(t_value v);
            logic [VW-1:0] m;
            m = magnitude(v) >> FB;
            if (v < 0) begin
                if (m > 64'h8000_0000) begin
                    m = 64'h8000_0000;
                end
                return 32'(-m);
            end
            if (m > 64'h7FFF_FFFF) begin
                m = 64'h7FFF_FFFF;
            end
            return 32'(m);
        endfunction

        // Advance the state by one accepted key and queue what it shows
        function void note_key(logic [7:0] key);
            t_display d;
            bit       by_zero;
            keys_taken++;
            d.kind  = kfc_pkg::KIND_DIGIT;
            d.echo  = key;
            d.shown = '0;
            d.dbz   = 1'b0;
            if (key >= kfc_pkg::KEY_0 && key <= kfc_pkg::KEY_9) begin
                if (on_second) begin
                    second_op = shift_digit(second_op, int'(key - kfc_pkg::KEY_0));
                end else begin
                    first_op = shift_digit(first_op, int'(key - kfc_pkg::KEY_0));
                end
                d.shown = 32'(key - kfc_pkg::KEY_0);
            end else if (key == kfc_pkg::KEY_PLUS || key == kfc_pkg::KEY_MINUS ||
                         key == kfc_pkg::KEY_STAR || key == kfc_pkg::KEY_SLASH) begin
                case (key)
                    kfc_pkg::KEY_PLUS:  pending_op = kfc_pkg::OP_ADD;
                    kfc_pkg::KEY_MINUS: pending_op = kfc_pkg::OP_SUB;
                    kfc_pkg::KEY_STAR:  pending_op = kfc_pkg::OP_MUL;
                    default:            pending_op = kfc_pkg::OP_DIV;
                endcase
                on_second = 1'b1;
                d.kind    = kfc_pkg::KIND_OPER;
            end else if (key == kfc_pkg::KEY_EQUALS) begin
                by_zero = 1'b0;
                case (pending_op)
                    kfc_pkg::OP_ADD:
                        last_value = clamp_value(t_wide'(first_op) + t_wide'(second_op));
                    kfc_pkg::OP_SUB:
                        last_value = clamp_value(t_wide'(first_op) - t_wide'(second_op));
                    kfc_pkg::OP_MUL:
                        last_value = mul_sat(first_op, second_op);
                    kfc_pkg::OP_DIV:
                        last_value = div_sat(first_op, second_op, by_zero);
                    default: ; // no operator: previous result stands
                endcase
                first_op  = last_value;
                second_op = '0;
                on_second = 1'b0;
                d.kind    = kfc_pkg::KIND_EQUALS;
                d.shown   = integer_part(last_value);
                d.dbz     = by_zero;
                equals_seen++;
                if (by_zero) begin
                    zero_divides++;
                end
            end else if (key == kfc_pkg::KEY_HASH) begin
                clear_state();
                d.kind = kfc_pkg::KIND_CLEAR;
            end else begin
                return;
            end
            display_q.push_back(d);
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] echo,
                                   logic signed [31:0] shown, logic dbz);
            t_display want;
            results_checked++;
            if (display_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result with nothing pending: kind %0d char %02h value %0d",
                             $realtime, kind, echo, shown);
                end
                return;
            end
            want = display_q.pop_front();
            if (want.kind !== kind || want.echo !== echo ||
                want.shown !== shown || want.dbz !== dbz) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch: expected kind %0d char %02h value %0d dbz %0b",
                             $realtime, want.kind, want.echo, want.shown, want.dbz);
                    $display("%0t:           got kind %0d char %02h value %0d dbz %0b",
                             $realtime, kind, echo, shown, dbz);
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         key_code = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         event_kind;
    logic [7:0]         echo_char;
    logic signed [31:0] shown_value;
    logic               divide_by_zero;

    int send_idle_pct = 9;
    int recv_idle_pct = 75;
    int random_keys = 0;

    calc_scoreboard board = new();

    keypad_four_function_calculator_core uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_key_code       (key_code),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_event_kind     (event_kind),
        .o_echo_char      (echo_char),
        .o_shown_value    (shown_value),
        .o_divide_by_zero (divide_by_zero)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result side: random stall, checked on the falling edge ahead of the edge that takes it
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(negedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            board.check_result(event_kind, echo_char, shown_value, divide_by_zero);
        end
    end

    // One request, with random idle cycles ahead of it
    task automatic send_key(input logic [7:0] key);
        logic stalled;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            key_code <= 8'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        key_code <= key;
        do begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
        board.note_key(key);
    endtask

    task automatic press(input logic [7:0] key);
        send_key(key);
        if ((key >= kfc_pkg::KEY_0 && key <= kfc_pkg::KEY_9) ||
            key == kfc_pkg::KEY_PLUS || key == kfc_pkg::KEY_MINUS ||
            key == kfc_pkg::KEY_STAR || key == kfc_pkg::KEY_SLASH ||
            key == kfc_pkg::KEY_EQUALS || key == kfc_pkg::KEY_HASH) begin
            random_keys++;
        end
    endtask

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(3))
            0:       return kfc_pkg::KEY_PLUS;
            1:       return kfc_pkg::KEY_MINUS;
            2:       return kfc_pkg::KEY_STAR;
            default: return kfc_pkg::KEY_SLASH;
        endcase
    endfunction

    // Mostly short numbers, now and then long enough to saturate
    task automatic enter_number();
        int n;
        n = ($urandom_range(7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
        repeat (n) press(8'(kfc_pkg::KEY_0 + $urandom_range(9)));
    endtask

    // Well-formed expression, sometimes chained onto the previous result
    task automatic run_expression();
        if ($urandom_range(9) == 0) begin
            press(kfc_pkg::KEY_HASH);
        end
        if ($urandom_range(2) != 0) begin
            enter_number();
        end
        press(pick_operator());
        if ($urandom_range(7) == 0) begin
            press(pick_operator());
        end
        enter_number();
        repeat (($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1) press(kfc_pkg::KEY_EQUALS);
    endtask

    initial begin
        string script;
        int    pick;
        int    i;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: unlisted keys, equals with no operator, all operators,
        // operator replaced, repeated equals, negative operand digit,
        // division by zero with negative and zero dividend
        send_key(8'h00);
        send_key(8'hFF);
        script = "#=90+*12==-999=3/0=#/=";
        for (i = 0; i < script.len(); i++) begin
            send_key(script[i]);
        end

        // Random: three idling phases
        random_keys = 0;
        while (random_keys < RANDOM_KEYS) begin
            if (random_keys < RANDOM_KEYS / 3) begin
                send_idle_pct = 9;
                recv_idle_pct = 75;
            end else if (random_keys < 2 * RANDOM_KEYS / 3) begin
                send_idle_pct = 75;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick = $urandom_range(99);
            if (pick < 80) begin
                run_expression();
            end else if (pick < 90) begin
                // noise: any byte at all
                repeat ($urandom_range(1, 4)) press(8'($urandom_range(255)));
            end else begin
                // broken: digits then equals with no operator, or a stray operator
                if ($urandom_range(1) == 0) begin
                    press(kfc_pkg::KEY_HASH);
                end
                enter_number();
                press(($urandom_range(1) == 0) ? kfc_pkg::KEY_EQUALS : pick_operator());
            end
        end
        in_valid <= 1'b0;

        // Drain, then give the slowest program time to show anything stray
        while (board.display_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (VW + FB + 20) @(posedge clk);

        $display("Covered %0d keys, %0d results checked, %0d equals results",
                 board.keys_taken, board.results_checked, board.equals_seen);
        $display("Division by zero hit %0d times, mismatches %0d, still pending %0d",
                 board.zero_divides, board.mismatches, board.display_q.size());
        if (board.mismatches == 0 && board.display_q.size() == 0) begin
            $display("keypad_four_function_calculator_core test passed");
        end else begin
            $display("keypad_four_function_calculator_core test failed");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #3_000_000;
        $display("Timeout with %0d results pending", board.display_q.size());
        $display("keypad_four_function_calculator_core test failed");
        $finish;
    end

endmodule
